// ===== design/multi_channel_countdown_timer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer_unit assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

// concurrent assertion with a fixed message
`define MCTU_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mctu assertion failed");

// concurrent assertion with its own message
`define MCTU_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ===== design/mctu_pkg.sv =====
// ----------------------------------------------------------------------------
// mctu_pkg
// types, register map and word layout of the countdown timer unit
// ----------------------------------------------------------------------------
package mctu_pkg;

  localparam int MAX_CHANNELS = 6;

  // input word: tdata = {source_ticks, write_data, reg_addr}, tuser = action
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int TICKS_W     = 3;
  localparam int ACTION_W    = 2;
  localparam int IN_TDATA_W  = 40;
  // output word: tdata = {pad, irq_out, pending_mask, read_data}
  localparam int PEND_W      = 6;
  localparam int OUT_TDATA_W = 40;

  localparam int ADDR_LSB    = 0;
  localparam int WDATA_LSB   = ADDR_LSB + ADDR_W;
  localparam int TICKS_LSB   = WDATA_LSB + DATA_W;
  localparam int RDATA_LSB   = 0;
  localparam int PEND_LSB    = RDATA_LSB + DATA_W;
  localparam int IRQ_BIT     = PEND_LSB + PEND_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // register word indexes
  localparam logic [ADDR_W-1:0] ADDR_IRQ_EN   = 5'd0;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_PEND = 5'd1;
  localparam logic [ADDR_W-1:0] ADDR_CH_BASE  = 5'd4;

  typedef enum logic [1:0] {
    SUB_CTRL     = 2'd0,
    SUB_INTERVAL = 2'd1,
    SUB_COUNT    = 2'd2,
    SUB_RSVD     = 2'd3
  } sub_e;

  // control word bits
  localparam int CTRL_RUN      = 0;
  localparam int CTRL_RELOAD   = 1;
  localparam int CTRL_SRC_LSB  = 2;
  localparam int CTRL_PSC_LSB  = 4;
  localparam int CTRL_SINGLE   = 7;
  localparam logic [7:0] CTRL_STORE_MASK = 8'hFD;

  typedef enum logic [1:0] {
    SRC_32K  = 2'd0,
    SRC_24M  = 2'd1,
    SRC_PLL  = 2'd2,
    SRC_NONE = 2'd3
  } source_e;

endpackage

// ===== design/multi_channel_countdown_timer_unit.sv =====
// an accepted input word waits in the input register, its result word in the output register
// throughput: one tick, register write or register read per cycle while each
// result is taken; all channels update in parallel in the single processing stage
// the input register lets the next word in while a result waits
// reset (rst_ni low, asynchronous) clears all timer and interrupt registers
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer_unit
// down-counting timer channels with prescaler, interrupt enable and pending
// ----------------------------------------------------------------------------
module multi_channel_countdown_timer_unit
  import mctu_pkg::*;
#(
  parameter int NUM_CHANNELS = MAX_CHANNELS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // reg_addr, write_data, source_ticks
  input  logic [ACTION_W-1:0]    s_axis_tuser,  // action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // read_data, pending_mask, irq_out, pad
);

  // input register
  logic                  in_valid_q, in_valid_d;
  logic [ACTION_W-1:0]   in_act_q;
  logic [ADDR_W-1:0]     in_addr_q;
  logic [DATA_W-1:0]     in_data_q;
  logic [TICKS_W-1:0]    in_ticks_q;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [DATA_W-1:0]     out_rdata_q, out_rdata_d;
  logic [PEND_W-1:0]     out_pend_q, out_pend_d;
  logic                  out_irq_q, out_irq_d;

  // timer state
  logic [7:0]              ctrl_q [NUM_CHANNELS];
  logic [7:0]              ctrl_d [NUM_CHANNELS];
  logic [DATA_W-1:0]       intv_q [NUM_CHANNELS];
  logic [DATA_W-1:0]       intv_d [NUM_CHANNELS];
  logic [DATA_W-1:0]       cnt_q  [NUM_CHANNELS];
  logic [DATA_W-1:0]       cnt_d  [NUM_CHANNELS];
  logic [6:0]              psc_q  [NUM_CHANNELS];
  logic [6:0]              psc_d  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] en_q, en_d;
  logic [NUM_CHANNELS-1:0] pend_q, pend_d;

  logic              s_accept;
  logic              process;
  action_e           act;
  logic [ADDR_W-1:0] addr_off;
  logic [2:0]        chan;
  sub_e              sub;
  logic              chan_space;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign process       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || process;

  assign act        = action_e'(in_act_q);
  assign addr_off   = in_addr_q - ADDR_CH_BASE;
  assign chan       = addr_off[4:2];
  assign sub        = sub_e'(addr_off[1:0]);
  assign chan_space = (in_addr_q >= ADDR_CH_BASE);

  always_comb begin
    logic [NUM_CHANNELS-1:0] pend_set;
    logic                    hit;
    logic                    src_hit;
    logic [7:0]              last;
    logic [DATA_W-1:0]       cnt_dec;
    pend_set    = '0;
    out_rdata_d = '0;
    en_d        = en_q;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ctrl_d[i] = ctrl_q[i];
      intv_d[i] = intv_q[i];
      cnt_d[i]  = cnt_q[i];
      psc_d[i]  = psc_q[i];
      hit       = chan_space && (chan == 3'(i));
      unique case (source_e'(ctrl_q[i][CTRL_SRC_LSB +: 2]))
        SRC_32K:  src_hit = in_ticks_q[0];
        SRC_24M:  src_hit = in_ticks_q[1];
        SRC_PLL:  src_hit = in_ticks_q[2];
        SRC_NONE: src_hit = 1'b0;
        default:  src_hit = 1'b0;
      endcase
      last    = (8'd1 << ctrl_q[i][CTRL_PSC_LSB +: 3]) - 8'd1;
      cnt_dec = (cnt_q[i] != '0) ? cnt_q[i] - 32'd1 : cnt_q[i];

      unique case (act)
        ACT_TICK: begin
          if (ctrl_q[i][CTRL_RUN] && src_hit) begin
            if ({1'b0, psc_q[i]} >= last) begin
              psc_d[i] = '0;
              if (cnt_dec == '0) begin
                pend_set[i] = 1'b1;
                if (ctrl_q[i][CTRL_SINGLE]) begin
                  ctrl_d[i][CTRL_RUN] = 1'b0;
                  cnt_d[i]            = cnt_dec;
                end else begin
                  cnt_d[i] = intv_q[i];
                end
              end else begin
                cnt_d[i] = cnt_dec;
              end
            end else begin
              psc_d[i] = psc_q[i] + 7'd1;
            end
          end
        end
        ACT_WRITE: begin
          if (hit) begin
            unique case (sub)
              SUB_CTRL: begin
                ctrl_d[i] = in_data_q[7:0] & CTRL_STORE_MASK;
                if (in_data_q[CTRL_RELOAD]) begin
                  cnt_d[i] = intv_q[i];
                  psc_d[i] = '0;
                end
              end
              SUB_INTERVAL: intv_d[i] = in_data_q;
              SUB_COUNT:    cnt_d[i]  = in_data_q;
              SUB_RSVD:     ;
              default:      ;
            endcase
          end
        end
        ACT_READ: begin
          if (hit) begin
            unique case (sub)
              SUB_CTRL:     out_rdata_d = 32'(ctrl_q[i]);
              SUB_INTERVAL: out_rdata_d = intv_q[i];
              SUB_COUNT:    out_rdata_d = cnt_q[i];
              SUB_RSVD:     ;
              default:      ;
            endcase
          end
        end
        ACT_NONE: ;
        default: ;
      endcase
    end

    pend_d = pend_q | pend_set;
    if (act == ACT_WRITE && in_addr_q == ADDR_IRQ_EN) begin
      en_d = in_data_q[NUM_CHANNELS-1:0];
    end
    if (act == ACT_WRITE && in_addr_q == ADDR_IRQ_PEND) begin
      pend_d = pend_q & ~in_data_q[NUM_CHANNELS-1:0];
    end
    if (act == ACT_READ && in_addr_q == ADDR_IRQ_EN) begin
      out_rdata_d = 32'(en_q);
    end
    if (act == ACT_READ && in_addr_q == ADDR_IRQ_PEND) begin
      out_rdata_d = 32'(pend_q);
    end
  end

  assign out_pend_d  = PEND_W'(pend_d);
  assign out_irq_d   = |(pend_d & en_d);
  assign in_valid_d  = s_accept ? 1'b1 : (process ? 1'b0 : in_valid_q);
  assign out_valid_d = process ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  // handshake control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input word
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_act_q   <= s_axis_tuser;
      in_addr_q  <= s_axis_tdata[ADDR_LSB +: ADDR_W];
      in_data_q  <= s_axis_tdata[WDATA_LSB +: DATA_W];
      in_ticks_q <= s_axis_tdata[TICKS_LSB +: TICKS_W];
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (process) begin
      out_rdata_q <= out_rdata_d;
      out_pend_q  <= out_pend_d;
      out_irq_q   <= out_irq_d;
    end
  end

  // timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ctrl_q[i] <= '0;
        intv_q[i] <= '0;
        cnt_q[i]  <= '0;
        psc_q[i]  <= '0;
      end
      en_q   <= '0;
      pend_q <= '0;
    end else if (process) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ctrl_q[i] <= ctrl_d[i];
        intv_q[i] <= intv_d[i];
        cnt_q[i]  <= cnt_d[i];
        psc_q[i]  <= psc_d[i];
      end
      en_q   <= en_d;
      pend_q <= pend_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - IRQ_BIT - 1)'(0), out_irq_q, out_pend_q, out_rdata_q};

endmodule

// ===== design/mctu_checker.sv =====
// ----------------------------------------------------------------------------
// mctu_checker
// port-level checks of the countdown timer unit, bound to the top level
// ----------------------------------------------------------------------------
module mctu_checker
  import mctu_pkg::*;
#(
  parameter int NUM_CHANNELS = MAX_CHANNELS
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata    // read_data, pending_mask, irq_out, pad
);

`include "multi_channel_countdown_timer_unit_assert.svh"

  logic [PEND_W-1:0] pend;
  logic              irq;
  logic              in_acc;

  assign pend   = m_axis_tdata[PEND_LSB +: PEND_W];
  assign irq    = m_axis_tdata[IRQ_BIT];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result word holds
  `MCTU_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // the interrupt needs a pending channel
  `MCTU_ASSERT_MSG(a_irq_pend, m_axis_tvalid && irq |-> pend != '0, "irq without pending bit")

  // no pending bit above the channel count
  `MCTU_ASSERT_MSG(a_pend_range, m_axis_tvalid |-> (pend >> NUM_CHANNELS) == '0, "pending bit out of range")

  // a fresh result follows a word accepted into the input register
  `MCTU_ASSERT(a_out_source, $rose(m_axis_tvalid) |-> $past(in_acc, 2))

endmodule

bind multi_channel_countdown_timer_unit mctu_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_mctu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/multi_channel_countdown_timer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer_unit_tb
// drives ticks, register writes and reads into the timer unit and checks each
// status word against a shadow copy of the channel and interrupt registers
// ----------------------------------------------------------------------------
module multi_channel_countdown_timer_unit_tb;
  import mctu_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] rdata;
    logic [PEND_W-1:0] pend;
    logic              irq;
  } status_t;

  class timer_shadow;
    logic [7:0]        ctrl     [MAX_CHANNELS];
    logic [DATA_W-1:0] interval [MAX_CHANNELS];
    logic [DATA_W-1:0] count    [MAX_CHANNELS];
    logic [6:0]        psc_cnt  [MAX_CHANNELS];
    logic [PEND_W-1:0] irq_en;
    logic [PEND_W-1:0] irq_pend;
    status_t           status_due [$];
    int                errors;

    function new();
      for (int n = 0; n < MAX_CHANNELS; n++) begin
        ctrl[n]     = '0;
        interval[n] = '0;
        count[n]    = '0;
        psc_cnt[n]  = '0;
      end
      irq_en   = '0;
      irq_pend = '0;
      errors   = 0;
    endfunction

    function void count_down(int n);
      if (count[n] != 0) count[n] = count[n] - 1;
      if (count[n] == 0) begin
        irq_pend[n] = 1'b1;
        if (ctrl[n][CTRL_SINGLE]) ctrl[n][CTRL_RUN] = 1'b0;
        else count[n] = interval[n];
      end
    endfunction

    function void tick(logic [TICKS_W-1:0] srcs);
      source_e    src;
      logic [7:0] last;
      for (int n = 0; n < MAX_CHANNELS; n++) begin
        src  = source_e'(ctrl[n][CTRL_SRC_LSB +: 2]);
        last = (8'd1 << ctrl[n][CTRL_PSC_LSB +: 3]) - 8'd1;
        if (ctrl[n][CTRL_RUN] && src != SRC_NONE && srcs[src]) begin
          if ({1'b0, psc_cnt[n]} >= last) begin
            psc_cnt[n] = '0;
            count_down(n);
          end else begin
            psc_cnt[n] = psc_cnt[n] + 7'd1;
          end
        end
      end
    endfunction

    function void reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      logic [ADDR_W-1:0] off;
      int                n;
      off = addr - ADDR_CH_BASE;
      n   = int'(off >> 2);
      if (addr == ADDR_IRQ_EN) begin
        irq_en = data[PEND_W-1:0];
      end else if (addr == ADDR_IRQ_PEND) begin
        irq_pend = irq_pend & ~data[PEND_W-1:0];
      end else if (addr >= ADDR_CH_BASE && n < MAX_CHANNELS) begin
        case (sub_e'(off[1:0]))
          SUB_CTRL: begin
            ctrl[n] = data[7:0] & CTRL_STORE_MASK;
            if (data[CTRL_RELOAD]) begin
              count[n]   = interval[n];
              psc_cnt[n] = '0;
            end
          end
          SUB_INTERVAL: interval[n] = data;
          SUB_COUNT:    count[n] = data;
          default: ;
        endcase
      end
    endfunction

    function logic [DATA_W-1:0] reg_read(logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] off;
      int                n;
      off = addr - ADDR_CH_BASE;
      n   = int'(off >> 2);
      if (addr == ADDR_IRQ_EN) return DATA_W'(irq_en);
      if (addr == ADDR_IRQ_PEND) return DATA_W'(irq_pend);
      if (addr < ADDR_CH_BASE || n >= MAX_CHANNELS) return '0;
      case (sub_e'(off[1:0]))
        SUB_CTRL:     return DATA_W'(ctrl[n]);
        SUB_INTERVAL: return interval[n];
        SUB_COUNT:    return count[n];
        default:      return '0;
      endcase
    endfunction

    // accepted input word: update the shadow and queue the status it causes
    function void apply_word(action_e act, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] data, logic [TICKS_W-1:0] srcs);
      status_t st;
      st.rdata = '0;
      case (act)
        ACT_TICK:  tick(srcs);
        ACT_WRITE: reg_write(addr, data);
        ACT_READ:  st.rdata = reg_read(addr);
        default: ;
      endcase
      st.pend = irq_pend;
      st.irq  = |(irq_pend & irq_en);
      status_due.push_back(st);
    endfunction

    task report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      errors++;
      $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
    endtask

    task check_word(logic [OUT_TDATA_W-1:0] w);
      status_t st;
      if (status_due.size() == 0) begin
        report("word with nothing due", '0, w[DATA_W-1:0]);
      end else begin
        st = status_due.pop_front();
        if (w[RDATA_LSB +: DATA_W] !== st.rdata)
          report("read_data", st.rdata, w[RDATA_LSB +: DATA_W]);
        if (w[PEND_LSB +: PEND_W] !== st.pend)
          report("pending_mask", DATA_W'(st.pend), DATA_W'(w[PEND_LSB +: PEND_W]));
        if (w[IRQ_BIT] !== st.irq)
          report("irq_out", DATA_W'(st.irq), DATA_W'(w[IRQ_BIT]));
      end
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [ACTION_W-1:0]    s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  timer_shadow shadow = new();
  int          send_idle = 0;
  int          recv_idle = 0;

  multi_channel_countdown_timer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= recv_idle);
    end
  end

  // inputs noted before outputs so a word is due before its status can arrive
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        shadow.apply_word(action_e'(s_axis_tuser), s_axis_tdata[ADDR_LSB +: ADDR_W],
                          s_axis_tdata[WDATA_LSB +: DATA_W],
                          s_axis_tdata[TICKS_LSB +: TICKS_W]);
      if (m_axis_tvalid && m_axis_tready) shadow.check_word(m_axis_tdata);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(action_e act, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] data, logic [TICKS_W-1:0] srcs);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {srcs, data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] chan_addr(int n, sub_e sub);
    return ADDR_CH_BASE + ADDR_W'(4 * n) + ADDR_W'(sub);
  endfunction

  // mostly small so channels run out often
  function automatic logic [DATA_W-1:0] small_value();
    return ($urandom_range(7) == 0) ? $urandom() : DATA_W'($urandom_range(6));
  endfunction

  // returns 1 when the word does real work, 0 for noise
  task automatic random_word(output bit counted);
    int                r;
    int                n;
    logic [7:0]        c;
    logic [ADDR_W-1:0] a;
    r       = $urandom_range(99);
    n       = $urandom_range(MAX_CHANNELS - 1);
    counted = 1'b1;
    if (r < 50) begin
      send_word(ACT_TICK, ADDR_W'($urandom()), $urandom(), TICKS_W'($urandom_range(7)));
    end else if (r < 62) begin
      c[CTRL_RUN]            = ($urandom_range(99) < 85);
      c[CTRL_RELOAD]         = 1'($urandom_range(1));
      c[CTRL_SRC_LSB +: 2]   = 2'($urandom_range(3));
      c[CTRL_PSC_LSB +: 3]   = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                        : 3'($urandom_range(2));
      c[CTRL_SINGLE]         = 1'($urandom_range(1));
      send_word(ACT_WRITE, chan_addr(n, SUB_CTRL), {24'($urandom()), c},
                TICKS_W'($urandom()));
    end else if (r < 72) begin
      send_word(ACT_WRITE, chan_addr(n, SUB_INTERVAL), small_value(), TICKS_W'($urandom()));
    end else if (r < 77) begin
      send_word(ACT_WRITE, chan_addr(n, SUB_COUNT), small_value(), TICKS_W'($urandom()));
    end else if (r < 90) begin
      send_word(ACT_READ, ADDR_W'($urandom()), $urandom(), TICKS_W'($urandom()));
    end else if (r < 95) begin
      a = $urandom_range(1) ? ADDR_IRQ_EN : ADDR_IRQ_PEND;
      send_word(ACT_WRITE, a, $urandom(), TICKS_W'($urandom()));
    end else begin
      counted = 1'b0;
      if ($urandom_range(1))
        send_word(ACT_NONE, ADDR_W'($urandom()), $urandom(), TICKS_W'($urandom()));
      else
        send_word(ACT_WRITE, ADDR_W'($urandom_range(28, 31)), $urandom(),
                  TICKS_W'($urandom()));
    end
  endtask

  initial begin
    bit counted;
    int done;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_NONE;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, no idling
    send_word(ACT_WRITE, ADDR_IRQ_EN, 32'hFFFF_FFFF, 3'b000);
    send_word(ACT_READ,  ADDR_IRQ_EN, 32'h0, 3'b000);
    send_word(ACT_WRITE, chan_addr(0, SUB_INTERVAL), 32'd3, 3'b000);
    // run, reload, 32k source, no prescale, continuous
    send_word(ACT_WRITE, chan_addr(0, SUB_CTRL), 32'h0000_0003, 3'b000);
    send_word(ACT_READ,  chan_addr(0, SUB_CTRL), 32'h0, 3'b000);
    repeat (4) send_word(ACT_TICK, 5'd0, 32'h0, 3'b111);
    send_word(ACT_WRITE, ADDR_IRQ_PEND, 32'hFFFF_FFFF, 3'b000);
    // single mode on a count already at zero
    send_word(ACT_WRITE, chan_addr(1, SUB_CTRL), 32'h0000_0085, 3'b000);
    send_word(ACT_TICK,  5'd31, 32'hFFFF_FFFF, 3'b010);
    send_word(ACT_READ,  chan_addr(1, SUB_CTRL), 32'h0, 3'b000);
    // largest interval and prescale on the pll source
    send_word(ACT_WRITE, chan_addr(2, SUB_INTERVAL), 32'hFFFF_FFFF, 3'b000);
    send_word(ACT_WRITE, chan_addr(2, SUB_CTRL), 32'hFFFF_FFFB, 3'b000);
    send_word(ACT_TICK,  5'd0, 32'h0, 3'b100);
    send_word(ACT_READ,  chan_addr(2, SUB_COUNT), 32'h0, 3'b000);
    // no source selected on the last channel
    send_word(ACT_WRITE, chan_addr(5, SUB_CTRL), 32'h0000_000F, 3'b000);
    send_word(ACT_TICK,  5'd0, 32'h0, 3'b111);
    send_word(ACT_WRITE, chan_addr(3, SUB_COUNT), 32'hFFFF_FFFF, 3'b000);
    send_word(ACT_READ,  chan_addr(3, SUB_COUNT), 32'h0, 3'b000);
    send_word(ACT_READ,  5'd3, 32'h0, 3'b000);
    send_word(ACT_READ,  chan_addr(1, SUB_RSVD), 32'h0, 3'b000);
    send_word(ACT_WRITE, 5'd30, 32'hFFFF_FFFF, 3'b111);
    send_word(ACT_READ,  5'd31, 32'h0, 3'b000);
    send_word(ACT_NONE,  ADDR_IRQ_EN, 32'h0, 3'b111);
    send_word(ACT_WRITE, ADDR_IRQ_EN, 32'h0, 3'b000);

    // random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 21; recv_idle = 45; end
        1: begin send_idle = 45; recv_idle = 21; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      done = 0;
      while (done < 120) begin
        random_word(counted);
        if (counted) done++;
      end
      // hold off until the status queue drains
      s_axis_tvalid = 1'b0;
      while (shadow.status_due.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
    end

    repeat (10) @(posedge clk_i);
    if (shadow.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
